// ===== src/iate_pkg.sv =====
// ---------------------------------------------------------------------------
// iate_pkg
// Shared widths, codes and types of the indexed array table engine.
// ---------------------------------------------------------------------------
package iate_pkg;

  // field widths
  localparam int unsigned REQ_W = 2;
  localparam int unsigned POS_W = 6;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned ST_W  = 2;

  // default number of cells
  localparam int unsigned CAPACITY_DEF = 64;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND    = 2'd0,
    REQ_OVERWRITE = 2'd1,
    REQ_DELETE    = 2'd2,
    REQ_SEARCH    = 2'd3
  } req_type_t;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // control states
  typedef enum logic {
    S_IDLE  = 1'b0,
    S_DRAIN = 1'b1
  } state_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic             en;
    req_type_t        op;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
    logic [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

// ===== src/iate_ifs.sv =====
// ---------------------------------------------------------------------------
// iate_ifs
// Valid/ready channels for request items and result items.
// ---------------------------------------------------------------------------
interface iate_req_if;
  import iate_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] operand_value;

  modport source (output valid, req_type, position, operand_value, input ready);
  modport sink   (input valid, req_type, position, operand_value, output ready);
endinterface

interface iate_rsp_if;
  import iate_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic [POS_W-1:0]        found_index;
  logic signed [VAL_W-1:0] old_value;
  logic [CNT_W-1:0]        element_count;
  logic                    last_result;

  modport source (output valid, status, found_index, old_value, element_count,
                  last_result, input ready);
  modport sink   (input valid, status, found_index, old_value, element_count,
                  last_result, output ready);
endinterface

// ===== src/iate_cell.sv =====
// ---------------------------------------------------------------------------
// iate_cell
// One list slot: holds one element, writes on append or overwrite, takes its
// upper neighbor's element on a delete at or below it, and compares for search.
// ---------------------------------------------------------------------------
module iate_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                          clk,
  input  iate_pkg::cell_ctl_t           ctl,
  input  logic [iate_pkg::VAL_W-1:0]    nbr_value,
  output logic [iate_pkg::VAL_W-1:0]    value,
  output logic                          hit
);
  import iate_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [VAL_W-1:0] value_r;
  logic [VAL_W-1:0] value_nxt;
  logic             in_use;
  logic             wr_en;
  logic             sh_en;

  // slot holds a live element
  assign in_use = MY_IDX < ctl.cnt;

  // write on append at the tail or overwrite of a live slot
  assign wr_en = ctl.en &&
                 ((ctl.op == REQ_APPEND && ctl.cnt == MY_IDX) ||
                  (ctl.op == REQ_OVERWRITE && ctl.pos == MY_IDX && in_use));

  // close the gap: every slot at or above the deleted one moves down
  assign sh_en = ctl.en && ctl.op == REQ_DELETE && ctl.pos < ctl.cnt &&
                 MY_IDX >= ctl.pos;

  always_comb begin
    value_nxt = value_r;
    if (wr_en) begin
      value_nxt = ctl.value;
    end else if (sh_en) begin
      value_nxt = nbr_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  // search compare on live slots only
  assign hit   = in_use && (value_r == ctl.value);
  assign value = value_r;

endmodule

// ===== src/indexed_array_table_engine_core.sv =====
// The row of cells updates all slots at once. A result is registered in the cycle
// after acceptance; a search with hits loads its hit mask register first.
// Throughput: one request per cycle for append, overwrite, delete and searches
// without hits while the result channel is free; a search with hits sends one
// item per free cycle and takes no new request until its last hit is out.
// Reset clears the element count, control state and output valid; cells are not.
// ---------------------------------------------------------------------------
// indexed_array_table_engine_core
// Bounded ordered list of signed values built as a row of cells, with append,
// overwrite, delete and search.
// ---------------------------------------------------------------------------
module indexed_array_table_engine_core #(
  parameter int unsigned CAPACITY = iate_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  iate_req_if.sink   in_chan,
  iate_rsp_if.source out_chan
);
  import iate_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // lowest set bit of the hit mask
  function automatic logic [POS_W-1:0] first_hit(input logic [CAPACITY-1:0] m);
    logic [POS_W-1:0] idx;
    idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = POS_W'(i);
      end
    end
    return idx;
  endfunction

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CAPACITY-1:0] match_r, match_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [POS_W-1:0]  idx_r, idx_nxt;
  logic [VAL_W-1:0]  old_r, old_nxt;
  logic [CNT_W-1:0]  ecnt_r, ecnt_nxt;
  logic              last_r, last_nxt;

  logic              out_free;
  logic              accept;
  logic              full;
  logic              pos_ok;
  logic [CNT_W-1:0]  pos_ext;
  cell_ctl_t         ctl;
  logic [VAL_W-1:0]  cell_val [CAPACITY];
  logic [CAPACITY-1:0] hits;
  logic [VAL_W-1:0]  old_sel;
  logic [CAPACITY-1:0] rest;

  // handshake
  assign out_free      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE) && out_free;
  assign accept        = in_chan.valid && in_chan.ready;

  assign pos_ext = {1'b0, in_chan.position};
  assign full    = cnt_r >= CAP_CNT;
  assign pos_ok  = pos_ext < cnt_r;

  // broadcast to the cells
  always_comb begin
    ctl.en    = accept;
    ctl.op    = req_type_t'(in_chan.req_type);
    ctl.pos   = pos_ext;
    ctl.cnt   = cnt_r;
    ctl.value = in_chan.operand_value;
  end

  // row of cells, each fed by its upper neighbor, the top one by zero
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] nbr;
    if (g == CAPACITY - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_val[g+1];
    end
    iate_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .nbr_value (nbr),
      .value     (cell_val[g]),
      .hit       (hits[g])
    );
  end

  // old value read-out for overwrite
  always_comb begin
    old_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      old_sel = old_sel | (cell_val[i] & {VAL_W{pos_ext == CNT_W'(i)}});
    end
  end

  // hit mask with its lowest bit cleared
  assign rest = match_r & (match_r - 1'b1);

  // next state and result
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    match_nxt     = match_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    status_nxt    = status_r;
    idx_nxt       = idx_r;
    old_nxt       = old_r;
    ecnt_nxt      = ecnt_r;
    last_nxt      = last_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          idx_nxt       = '0;
          old_nxt       = '0;
          last_nxt      = 1'b1;
          case (ctl.op)
            REQ_APPEND: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            REQ_OVERWRITE: begin
              if (pos_ok) begin
                old_nxt = old_sel;
              end else begin
                status_nxt = ST_RANGE;
              end
            end
            REQ_DELETE: begin
              if (pos_ok) begin
                cnt_nxt = cnt_r - 1'b1;
              end else begin
                status_nxt = ST_RANGE;
              end
            end
            REQ_SEARCH: begin
              if (hits == '0) begin
                status_nxt = ST_NOTFOUND;
              end else begin
                out_valid_nxt = out_valid_r && !out_chan.ready;
                status_nxt    = status_r;
                idx_nxt       = idx_r;
                last_nxt      = last_r;
                old_nxt       = old_r;
                match_nxt     = hits;
                state_nxt     = S_DRAIN;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
          ecnt_nxt = cnt_nxt;
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          idx_nxt       = first_hit(match_r);
          old_nxt       = '0;
          ecnt_nxt      = cnt_r;
          last_nxt      = (rest == '0);
          match_nxt     = rest;
          if (rest == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    match_r  <= match_nxt;
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    old_r    <= old_nxt;
    ecnt_r   <= ecnt_nxt;
    last_r   <= last_nxt;
  end

  // result channel
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = status_r;
  assign out_chan.found_index   = idx_r;
  assign out_chan.old_value     = old_r;
  assign out_chan.element_count = ecnt_r;
  assign out_chan.last_result   = last_r;

  // count stays within the row of cells
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("element count above capacity");

  // draining always has a hit left to send
  a_drain_mask: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |-> match_r != '0)
    else $error("drain state with empty hit mask");

  // a successful append grows the list by one
  a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ctl.op == REQ_APPEND && !full |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("append did not grow the list");

  // the final item of a drain returns control to idle
  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN && out_free && rest == '0 |=> state_r == S_IDLE && last_r)
    else $error("drain did not end on the last hit");

endmodule

// ===== bench/tb_indexed_array_table_engine_core.sv =====
// ---------------------------------------------------------------------------
// tb_indexed_array_table_engine_core
// Self-checking bench for the bounded list engine. A short table of requests
// walks the empty list, the value extremes, overwrite, delete and search, and
// the range and not-found statuses. Randomized phases of appends, overwrites,
// deletes and searches follow: filling up to full, draining down to empty, and
// runs of duplicate values that give long search hit lists. Every result item
// is checked field by field against a shadow copy of the list, with random
// stalls on both channels.
// ---------------------------------------------------------------------------
module tb_indexed_array_table_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import iate_pkg::*;

  localparam int unsigned LIST_CAP      = CAPACITY_DEF;
  localparam int          PHASE_LEN     = 70;
  localparam int          SETTLE_CYCLES = 10;
  // worst correct run is ~450 searches x 64 results each, with stalls
  localparam int          CYCLE_LIMIT   = 400000;

  // one result item
  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] found_index;
    logic [VAL_W-1:0] old_value;
    logic [CNT_W-1:0] element_count;
    logic             last_result;
  } rsp_item_t;

  // one request, with its result typed in where it is obvious
  typedef struct packed {
    req_type_t        op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic             typed;
    rsp_item_t        rsp;
  } request_t;

  typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_DUPES} mix_t;

  localparam rsp_item_t NO_RSP = '{ST_OK, 6'd0, 32'h0, 7'd0, 1'b0};

  // directed requests, starting from the empty list
  localparam request_t DIRECTED [25] = '{
    '{REQ_SEARCH,    6'd0,  32'h0000_0000, 1'b1, '{ST_NOTFOUND, 6'd0, 32'h0, 7'd0, 1'b1}},
    '{REQ_OVERWRITE, 6'd0,  32'h0000_0001, 1'b1, '{ST_RANGE, 6'd0, 32'h0, 7'd0, 1'b1}},
    '{REQ_DELETE,    6'd63, 32'h0000_0000, 1'b1, '{ST_RANGE, 6'd0, 32'h0, 7'd0, 1'b1}},
    '{REQ_APPEND,    6'd0,  32'h8000_0000, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd1, 1'b1}},
    '{REQ_APPEND,    6'd63, 32'h7fff_ffff, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd2, 1'b1}},
    '{REQ_APPEND,    6'd0,  32'h0000_0000, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd3, 1'b1}},
    '{REQ_APPEND,    6'd0,  32'hffff_ffff, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd4, 1'b1}},
    '{REQ_APPEND,    6'd0,  32'h7fff_ffff, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd5, 1'b1}},
    '{REQ_SEARCH,    6'd63, 32'h7fff_ffff, 1'b0, NO_RSP},
    '{REQ_SEARCH,    6'd0,  32'h8000_0000, 1'b0, NO_RSP},
    '{REQ_OVERWRITE, 6'd1,  32'hffff_ffff, 1'b1,
      '{ST_OK, 6'd0, 32'h7fff_ffff, 7'd5, 1'b1}},
    '{REQ_OVERWRITE, 6'd5,  32'h0000_0000, 1'b1, '{ST_RANGE, 6'd0, 32'h0, 7'd5, 1'b1}},
    '{REQ_DELETE,    6'd63, 32'h0000_0000, 1'b1, '{ST_RANGE, 6'd0, 32'h0, 7'd5, 1'b1}},
    '{REQ_SEARCH,    6'd0,  32'hffff_ffff, 1'b0, NO_RSP},
    '{REQ_DELETE,    6'd0,  32'h0000_0000, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd4, 1'b1}},
    '{REQ_SEARCH,    6'd0,  32'hffff_ffff, 1'b0, NO_RSP},
    '{REQ_DELETE,    6'd3,  32'h0000_0000, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd3, 1'b1}},
    '{REQ_DELETE,    6'd3,  32'h0000_0000, 1'b1, '{ST_RANGE, 6'd0, 32'h0, 7'd3, 1'b1}},
    '{REQ_SEARCH,    6'd0,  32'h0000_3039, 1'b1, '{ST_NOTFOUND, 6'd0, 32'h0, 7'd3, 1'b1}},
    '{REQ_OVERWRITE, 6'd2,  32'h8000_0000, 1'b0, NO_RSP},
    '{REQ_DELETE,    6'd1,  32'h0000_0000, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd2, 1'b1}},
    '{REQ_SEARCH,    6'd0,  32'h0000_0000, 1'b1, '{ST_NOTFOUND, 6'd0, 32'h0, 7'd2, 1'b1}},
    '{REQ_DELETE,    6'd0,  32'h0000_0000, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd1, 1'b1}},
    '{REQ_DELETE,    6'd0,  32'h0000_0000, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd0, 1'b1}},
    '{REQ_DELETE,    6'd0,  32'h0000_0000, 1'b1, '{ST_RANGE, 6'd0, 32'h0, 7'd0, 1'b1}}
  };

  localparam mix_t PHASE_PLAN [6] = '{MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_DUPES,
                                      MIX_DRAIN, MIX_BALANCED};

  localparam logic [VAL_W-1:0] CORNER_VALS [6] = '{32'h0000_0000, 32'h0000_0001,
    32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h5555_5555};

  logic clk;
  logic rst_n;

  iate_req_if req_chan ();
  iate_rsp_if rsp_chan ();

  // shadow copy of the list
  logic [VAL_W-1:0] list_vals [LIST_CAP];
  int               list_len;

  request_t  request_log [$];
  rsp_item_t list_rsps [$];
  rsp_item_t pending_rsps [$];

  int error_count;
  int cycle_count;
  int src_idle_pct;
  int sink_idle_pct;

  indexed_array_table_engine_core #(
    .CAPACITY (LIST_CAP)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (rsp_chan)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run-time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result item of the shadow list, count taken after the request
  function automatic void note_rsp(status_t st, int idx, logic [VAL_W-1:0] oldv,
                                   logic last);
    rsp_item_t r;
    r.status        = st;
    r.found_index   = idx[POS_W-1:0];
    r.old_value     = oldv;
    r.element_count = list_len[CNT_W-1:0];
    r.last_result   = last;
    list_rsps.push_back(r);
  endfunction

  // apply one request to the shadow list and collect its result items
  task automatic apply_to_list(input request_t r);
    int               hits [$];
    logic [VAL_W-1:0] prior;
    list_rsps.delete();
    case (r.op)
      REQ_APPEND: begin
        if (list_len >= LIST_CAP) begin
          note_rsp(ST_FULL, 0, '0, 1'b1);
        end else begin
          list_vals[list_len] = r.val;
          list_len++;
          note_rsp(ST_OK, 0, '0, 1'b1);
        end
      end
      REQ_OVERWRITE: begin
        if (int'(r.pos) >= list_len) begin
          note_rsp(ST_RANGE, 0, '0, 1'b1);
        end else begin
          prior             = list_vals[r.pos];
          list_vals[r.pos]  = r.val;
          note_rsp(ST_OK, 0, prior, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (int'(r.pos) >= list_len) begin
          note_rsp(ST_RANGE, 0, '0, 1'b1);
        end else begin
          list_len--;
          for (int i = r.pos; i < list_len; i++) list_vals[i] = list_vals[i+1];
          note_rsp(ST_OK, 0, '0, 1'b1);
        end
      end
      default: begin
        for (int i = 0; i < list_len; i++) begin
          if (list_vals[i] == r.val) hits.push_back(i);
        end
        if (hits.size() == 0) begin
          note_rsp(ST_NOTFOUND, 0, '0, 1'b1);
        end
        foreach (hits[k]) note_rsp(ST_OK, hits[k], '0, k == hits.size() - 1);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // result checking first, then accepted requests feed the shadow list
  always @(posedge clk) begin : watch
    rsp_item_t want;
    request_t  req;
    if (rst_n) begin
      if (rsp_chan.valid && rsp_chan.ready) begin
        if (pending_rsps.size() == 0) begin
          $error("result item with no request waiting on it");
          error_count++;
        end else begin
          want = pending_rsps.pop_front();
          check_field("status", VAL_W'(want.status), VAL_W'(rsp_chan.status));
          check_field("found_index", VAL_W'(want.found_index),
                      VAL_W'(rsp_chan.found_index));
          check_field("old_value", want.old_value, rsp_chan.old_value);
          check_field("element_count", VAL_W'(want.element_count),
                      VAL_W'(rsp_chan.element_count));
          check_field("last_result", VAL_W'(want.last_result),
                      VAL_W'(rsp_chan.last_result));
        end
      end
      if (req_chan.valid && req_chan.ready) begin
        req = request_log.pop_front();
        apply_to_list(req);
        if (req.typed) begin
          pending_rsps.push_back(req.rsp);
        end else begin
          foreach (list_rsps[k]) pending_rsps.push_back(list_rsps[k]);
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    rsp_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // offer one request, with a random gap ahead of it, and wait for acceptance
  task automatic send_request(input request_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req_chan.valid <= 1'b0;
      @(posedge clk);
    end
    request_log.push_back(r);
    req_chan.valid         <= 1'b1;
    req_chan.req_type      <= r.op;
    req_chan.position      <= r.pos;
    req_chan.operand_value <= r.val;
    do @(posedge clk); while (req_chan.ready !== 1'b1);
  endtask

  // stimulus
  initial begin : stim
    request_t         r;
    int               roll;
    int               sel;
    logic [VAL_W-1:0] dup_value;
    rst_n                  = 1'b0;
    req_chan.valid         = 1'b0;
    req_chan.req_type      = '0;
    req_chan.position      = '0;
    req_chan.operand_value = '0;
    list_len               = 0;
    error_count            = 0;
    cycle_count            = 0;
    src_idle_pct           = 37;
    sink_idle_pct          = 37;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (DIRECTED[i]) send_request(DIRECTED[i]);

    // random phases
    foreach (PHASE_PLAN[ph]) begin
      // last phase runs with no idling on either side
      if (ph == $size(PHASE_PLAN) - 1) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      dup_value = CORNER_VALS[$urandom_range(5)];
      for (int n = 0; n < PHASE_LEN; n++) begin
        roll = $urandom_range(99);
        case (PHASE_PLAN[ph])
          MIX_FILL:
            r.op = roll < 82 ? REQ_APPEND : roll < 88 ? REQ_OVERWRITE :
                   roll < 93 ? REQ_DELETE : REQ_SEARCH;
          MIX_BALANCED:
            r.op = roll < 30 ? REQ_APPEND : roll < 55 ? REQ_OVERWRITE :
                   roll < 75 ? REQ_DELETE : REQ_SEARCH;
          MIX_DRAIN:
            r.op = roll < 8 ? REQ_APPEND : roll < 15 ? REQ_OVERWRITE :
                   roll < 88 ? REQ_DELETE : REQ_SEARCH;
          default:
            r.op = roll < 88 ? REQ_APPEND : REQ_SEARCH;
        endcase

        // mostly in range or just past the end, sometimes anywhere
        if ($urandom_range(9) < 7) begin
          r.pos = POS_W'($urandom_range(list_len < 64 ? list_len : 63));
        end else begin
          r.pos = POS_W'($urandom_range(63));
        end

        // corner values, values already stored, or anything
        sel = $urandom_range(9);
        if (PHASE_PLAN[ph] == MIX_DUPES) begin
          r.val = dup_value;
        end else if (sel < 4) begin
          r.val = CORNER_VALS[$urandom_range(5)];
        end else if (sel < 7 && list_len > 0) begin
          r.val = list_vals[$urandom_range(list_len - 1)];
        end else begin
          r.val = $urandom;
        end
        r.typed = 1'b0;
        r.rsp   = NO_RSP;
        send_request(r);
      end
    end
    req_chan.valid <= 1'b0;

    // drain and settle
    while (request_log.size() != 0 || pending_rsps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
